### sv/rlbd_pkg.sv
// Shared types and constants for the resistor ladder button decoder.
package rlbd_pkg;

  localparam int MAX_BUTTONS = 5;
  localparam int BTN_W       = 3;
  localparam int CNT_W       = 3;
  localparam int SAMPLE_W    = 12;
  localparam int LEVEL_W     = 12;
  localparam int TIME_W      = 32;
  localparam int HOLD_W      = 16;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int Q_DEPTH     = 4;
  localparam int Q_IDX_W     = 2;
  localparam int Q_CNT_W     = 3;

  localparam logic [HOLD_W-1:0]  HOLD_RESET   = 16'd300;
  localparam logic [LEVEL_W-1:0] MARGIN_RESET = 12'd64;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_HOLD  = 2'd2
  } ev_t;

  typedef enum logic [2:0] {
    REG_BUTTON_COUNT = 3'd0,
    REG_HOLD_MS      = 3'd1,
    REG_MARGIN       = 3'd2,
    REG_LEVEL_0      = 3'd3,
    REG_LEVEL_1      = 3'd4,
    REG_LEVEL_2      = 3'd5,
    REG_LEVEL_3      = 3'd6,
    REG_LEVEL_4      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]                      button_count;
    logic [HOLD_W-1:0]                     hold_ms;
    logic [LEVEL_W-1:0]                    margin;
    logic [MAX_BUTTONS-1:0][LEVEL_W-1:0]   levels;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [BTN_W-1:0]  button;
    logic [TIME_W-1:0] time_ms;
  } cls_t;

  typedef struct packed {
    ev_t              ev;
    logic [BTN_W-1:0] button;
  } res_t;

endpackage

### sv/resistor_ladder_button_decoder.sv
// Top level: resistor ladder button decoder.
// An accepted sample is stored in the queue and then registered in the result buffer.
// Throughput: one sample per cycle while the queue is not full and results are popped.
// A four-entry queue between classifier and back end and a two-entry result buffer
// let input and output stall independently.
// Reset (synchronous, active high) restores register defaults and clears all queues.
module resistor_ladder_button_decoder
  import rlbd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                push,
  output logic                full,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [TIME_W-1:0]   time_ms,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          event_res,
  output logic [BTN_W-1:0]    button_index
);

  cfg_t cfg;
  cls_t cls;
  cls_t q_data;
  logic q_empty;
  logic q_pop;
  res_t res;

  rlbd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlbd_front u_front (
    .sample  (sample),
    .time_ms (time_ms),
    .cfg     (cfg),
    .cls     (cls)
  );

  rlbd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  rlbd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .hold_ms (cfg.hold_ms),
    .q       (q_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .res     (res),
    .empty   (empty),
    .pop     (pop)
  );

  assign event_res    = res.ev;
  assign button_index = res.button;

endmodule

### sv/rlbd_regs.sv
// Configuration register file with APB-style access.
module rlbd_regs
  import rlbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_count <= '0;
      cfg.hold_ms      <= HOLD_RESET;
      cfg.margin       <= MARGIN_RESET;
      cfg.levels       <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_BUTTON_COUNT: cfg.button_count <= pwdata[CNT_W-1:0];
        REG_HOLD_MS:      cfg.hold_ms      <= pwdata[HOLD_W-1:0];
        REG_MARGIN:       cfg.margin       <= pwdata[LEVEL_W-1:0];
        REG_LEVEL_0:      cfg.levels[0]    <= pwdata[LEVEL_W-1:0];
        REG_LEVEL_1:      cfg.levels[1]    <= pwdata[LEVEL_W-1:0];
        REG_LEVEL_2:      cfg.levels[2]    <= pwdata[LEVEL_W-1:0];
        REG_LEVEL_3:      cfg.levels[3]    <= pwdata[LEVEL_W-1:0];
        REG_LEVEL_4:      cfg.levels[4]    <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_BUTTON_COUNT: prdata = DATA_W'(cfg.button_count);
      REG_HOLD_MS:      prdata = DATA_W'(cfg.hold_ms);
      REG_MARGIN:       prdata = DATA_W'(cfg.margin);
      REG_LEVEL_0:      prdata = DATA_W'(cfg.levels[0]);
      REG_LEVEL_1:      prdata = DATA_W'(cfg.levels[1]);
      REG_LEVEL_2:      prdata = DATA_W'(cfg.levels[2]);
      REG_LEVEL_3:      prdata = DATA_W'(cfg.levels[3]);
      REG_LEVEL_4:      prdata = DATA_W'(cfg.levels[4]);
      default:          prdata = '0;
    endcase
  end

endmodule

### sv/rlbd_front.sv
// Front end: match each sample against the button windows and classify it.
module rlbd_front
  import rlbd_pkg::*;
(
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [TIME_W-1:0]   time_ms,
  input  cfg_t                cfg,
  output cls_t                cls
);

  logic [CNT_W-1:0]       n_used;
  logic [MAX_BUTTONS-1:0] hit;
  logic [LEVEL_W:0]       lv_hi [MAX_BUTTONS];
  logic [LEVEL_W:0]       s_hi;

  assign n_used = (cfg.button_count > CNT_W'(MAX_BUTTONS)) ?
                  CNT_W'(MAX_BUTTONS) : cfg.button_count;
  assign s_hi   = {1'b0, sample} + {1'b0, cfg.margin};

  always_comb begin
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      lv_hi[i] = {1'b0, cfg.levels[i]} + {1'b0, cfg.margin};
      hit[i]   = (CNT_W'(i) < n_used) &&
                 (lv_hi[i] > {1'b0, sample}) &&
                 ({1'b0, cfg.levels[i]} <= s_hi);
    end
  end

  always_comb begin
    cls.hit     = |hit;
    cls.button  = '0;
    cls.time_ms = time_ms;
    for (int i = MAX_BUTTONS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        cls.button = BTN_W'(i);
      end
    end
  end

endmodule

### sv/rlbd_queue.sv
// Short queue of classified samples between front and back.
module rlbd_queue
  import rlbd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t wdata,
  output logic full,
  input  logic pop,
  output cls_t rdata,
  output logic empty
);

  cls_t               mem [Q_DEPTH];
  logic [Q_IDX_W-1:0] wr_ptr;
  logic [Q_IDX_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] cnt;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt == Q_CNT_W'(Q_DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

### sv/rlbd_back.sv
// Back end: track the held button, raise short and hold events, buffer results.
module rlbd_back
  import rlbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [HOLD_W-1:0] hold_ms,
  input  cls_t              q,
  input  logic              q_empty,
  output logic              q_pop,
  output res_t              res,
  output logic              empty,
  input  logic              pop
);

  logic              held_valid;
  logic              held_valid_next;
  logic [BTN_W-1:0]  held_button;
  logic [BTN_W-1:0]  held_button_next;
  logic [TIME_W-1:0] press_time;
  logic [TIME_W-1:0] press_time_next;
  res_t              res_next;

  res_t              ob [2];
  logic              ohead;
  logic [1:0]        ocnt;
  logic              take;
  logic              drop;
  logic [TIME_W-1:0] elapsed;
  logic              early;
  logic              same;

  assign take    = !q_empty && (ocnt != 2'd2);
  assign q_pop   = take;
  assign empty   = (ocnt == 2'd0);
  assign drop    = pop && !empty;
  assign res     = ob[ohead];
  assign elapsed = q.time_ms - press_time;
  assign early   = elapsed < TIME_W'(hold_ms);
  assign same    = (held_valid == q.hit) && (!q.hit || held_button == q.button);

  always_comb begin
    held_valid_next  = held_valid;
    held_button_next = held_button;
    press_time_next  = press_time;
    res_next.ev      = EV_NONE;
    res_next.button  = '0;
    if (!same) begin
      if (held_valid && early) begin
        res_next.ev     = EV_SHORT;
        res_next.button = held_button;
      end
      held_valid_next  = q.hit;
      held_button_next = q.hit ? q.button : '0;
      if (q.hit) begin
        press_time_next = q.time_ms;
      end
    end else if (held_valid && !early) begin
      res_next.ev     = EV_HOLD;
      res_next.button = held_button;
      press_time_next = q.time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid  <= 1'b0;
      held_button <= '0;
      press_time  <= '0;
    end else if (take) begin
      held_valid  <= held_valid_next;
      held_button <= held_button_next;
      press_time  <= press_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ob[ohead ^ ocnt[0]] <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ohead <= 1'b0;
      ocnt  <= '0;
    end else begin
      if (drop) begin
        ohead <= ~ohead;
      end
      if (take && !drop) begin
        ocnt <= ocnt + 1'b1;
      end else if (drop && !take) begin
        ocnt <= ocnt - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_ocnt_range: assert property (@(posedge clk) disable iff (rst)
    ocnt != 2'd3)
    else $error("output buffer count out of range");

  a_short_needs_held: assert property (@(posedge clk) disable iff (rst)
    take && res_next.ev == EV_SHORT |-> held_valid && !same)
    else $error("short press without a held button");

  a_hold_button: assert property (@(posedge clk) disable iff (rst)
    take && res_next.ev == EV_HOLD |-> held_valid && res_next.button == held_button)
    else $error("hold event on wrong button");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    take && res_next.ev == EV_NONE |-> res_next.button == '0)
    else $error("button index set without event");

  a_hold_restart: assert property (@(posedge clk) disable iff (rst)
    take && res_next.ev == EV_HOLD |=> press_time == $past(q.time_ms))
    else $error("hold timer not restarted");
`endif

endmodule

### dv/button_event_checker.sv
// Checker for the ladder button decoder: tracks register writes, predicts events, compares results.
module button_event_checker
  import rlbd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic                push,
  input  logic                full,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [TIME_W-1:0]   time_ms,
  input  logic                empty,
  input  logic                pop,
  input  logic [1:0]          event_res,
  input  logic [BTN_W-1:0]    button_index,
  output int                  errors,
  output int                  outstanding,
  output int                  compared,
  output int                  shorts,
  output int                  holds
);

  cfg_t              cfg;
  logic              btn_down;
  logic [BTN_W-1:0]  btn_id;
  logic [TIME_W-1:0] btn_since;
  res_t              pending_events[$];

  function automatic int find_level(input logic [SAMPLE_W-1:0] s);
    int n;
    int i;
    int lv;
    int m;
    n = (cfg.button_count > MAX_BUTTONS) ? MAX_BUTTONS : int'(cfg.button_count);
    m = int'(cfg.margin);
    for (i = 0; i < n; i++) begin
      lv = int'(cfg.levels[i]);
      if (lv + m > int'(s) && lv - m <= int'(s)) return i;
    end
    return -1;
  endfunction

  task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    reg_idx_t idx;
    idx = reg_idx_t'(addr[ADDR_W-1:2]);
    case (idx)
      REG_BUTTON_COUNT: cfg.button_count = value[CNT_W-1:0];
      REG_HOLD_MS:      cfg.hold_ms = value[HOLD_W-1:0];
      REG_MARGIN:       cfg.margin = value[LEVEL_W-1:0];
      REG_LEVEL_0:      cfg.levels[0] = value[LEVEL_W-1:0];
      REG_LEVEL_1:      cfg.levels[1] = value[LEVEL_W-1:0];
      REG_LEVEL_2:      cfg.levels[2] = value[LEVEL_W-1:0];
      REG_LEVEL_3:      cfg.levels[3] = value[LEVEL_W-1:0];
      REG_LEVEL_4:      cfg.levels[4] = value[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic predict_event(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
    int               hit;
    logic             now_down;
    logic [BTN_W-1:0] now_id;
    logic [TIME_W-1:0] elapsed;
    res_t             r;
    hit = find_level(s);
    now_down = (hit >= 0);
    now_id = now_down ? BTN_W'(hit) : '0;
    elapsed = t - btn_since;
    r.ev = EV_NONE;
    r.button = '0;
    if (btn_down != now_down || (now_down && btn_id != now_id)) begin
      if (btn_down && elapsed < TIME_W'(cfg.hold_ms)) begin
        r.ev = EV_SHORT;
        r.button = btn_id;
      end
      btn_down = now_down;
      btn_id = now_id;
      if (now_down) btn_since = t;
    end else if (btn_down && elapsed >= TIME_W'(cfg.hold_ms)) begin
      r.ev = EV_HOLD;
      r.button = btn_id;
      btn_since = t;
    end
    pending_events.push_back(r);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      cfg.button_count = '0;
      cfg.hold_ms = HOLD_RESET;
      cfg.margin = MARGIN_RESET;
      cfg.levels = '0;
      btn_down = 1'b0;
      btn_id = '0;
      btn_since = '0;
      pending_events.delete();
      errors = 0;
      compared = 0;
      shorts = 0;
      holds = 0;
    end else begin
      if (psel && penable && pwrite && pready) write_register(paddr, pwdata);
      if (pop && !empty) begin
        if (pending_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got event %0d button %0d",
                   $time, event_res, button_index);
        end else begin
          want = pending_events.pop_front();
          compared++;
          if (want.ev == EV_SHORT) shorts++;
          if (want.ev == EV_HOLD) holds++;
          if (event_res !== want.ev) begin
            errors++;
            $display("%0t: event_res mismatch, expected %0d, got %0d",
                     $time, want.ev, event_res);
          end
          if (button_index !== want.button) begin
            errors++;
            $display("%0t: button_index mismatch, expected %0d, got %0d",
                     $time, want.button, button_index);
          end
        end
      end
      if (push && !full) predict_event(sample, time_ms);
    end
    outstanding = pending_events.size();
  end

endmodule

### dv/testbench.sv
// Top of the ladder button decoder testbench: clock, reset, register setup, sample traffic, verdict.
module testbench;
  import rlbd_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                push = 1'b0;
  logic                full;
  logic [SAMPLE_W-1:0] sample = '0;
  logic [TIME_W-1:0]   time_ms = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [1:0]          event_res;
  logic [BTN_W-1:0]    button_index;

  int errors;
  int outstanding;
  int compared;
  int shorts;
  int holds;

  int lvl [MAX_BUTTONS];
  int count_cur;
  int hold_cur;
  int margin_cur;
  int settings_count = 0;
  int samples_sent = 0;
  int burst_left = 0;
  int gap_max = 0;
  int stall_mode = 0;
  int pop_run = 0;
  logic pop_state = 1'b0;
  logic [TIME_W-1:0] now_ms;
  int phase;

  resistor_ladder_button_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .push         (push),
    .full         (full),
    .sample       (sample),
    .time_ms      (time_ms),
    .empty        (empty),
    .pop          (pop),
    .event_res    (event_res),
    .button_index (button_index)
  );

  button_event_checker event_check (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .push         (push),
    .full         (full),
    .sample       (sample),
    .time_ms      (time_ms),
    .empty        (empty),
    .pop          (pop),
    .event_res    (event_res),
    .button_index (button_index),
    .errors       (errors),
    .outstanding  (outstanding),
    .compared     (compared),
    .shorts       (shorts),
    .holds        (holds)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop_run == 0) begin
        pop_state = !pop_state;
        pop_run = pop_state ? $urandom_range(1, 16) : $urandom_range(1, stall_mode == 2 ? 12 : 3);
      end
      pop_run--;
      pop <= pop_state || (stall_mode == 0);
    end
  end

  initial begin
    #(8 * 400000);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_config(input int count, input int hold, input int mrg);
    int i;
    write_reg(REG_BUTTON_COUNT, count);
    write_reg(REG_HOLD_MS, hold);
    write_reg(REG_MARGIN, mrg);
    for (i = 0; i < MAX_BUTTONS; i++) write_reg(reg_idx_t'(REG_LEVEL_0 + i), lvl[i]);
    count_cur = (count > MAX_BUTTONS) ? MAX_BUTTONS : count;
    hold_cur = hold;
    margin_cur = mrg;
    settings_count++;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    push <= 1'b1;
    sample <= s;
    time_ms <= t;
    do @(posedge clk); while (full);
    burst_left--;
    samples_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [TIME_W-1:0] step_ms();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return TIME_W'($urandom_range(1, hold_cur / 3 + 1));
      4:       return TIME_W'(hold_cur) - 1;
      5:       return TIME_W'(hold_cur);
      6:       return TIME_W'(hold_cur) + 1;
      7, 8:    return TIME_W'($urandom_range(0, 2 * hold_cur + 2));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] level_sample(input int b);
    int lv;
    int lo;
    int hi;
    lv = lvl[b];
    lo = lv - margin_cur;
    hi = lv + margin_cur - 1;
    if (lo < 0) lo = 0;
    if (hi > 4095) hi = 4095;
    case ($urandom_range(0, 9))
      0:       return SAMPLE_W'(lo);
      1:       return SAMPLE_W'(hi < 0 ? 0 : hi);
      2:       return SAMPLE_W'(hi + 1 > 4095 ? 4095 : (hi + 1 < 0 ? 0 : hi + 1));
      default: return (hi < lo) ? SAMPLE_W'(lv) : SAMPLE_W'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic run_gestures(input int n);
    int sent;
    int len;
    int b;
    int k;
    sent = 0;
    while (sent < n) begin
      if (count_cur > 0 && $urandom_range(0, 99) < 85) begin
        b = $urandom_range(0, count_cur - 1);
        len = $urandom_range(1, 10);
        for (k = 0; k < len && sent < n; k++) begin
          now_ms += step_ms();
          send_sample(level_sample(b), now_ms);
          sent++;
        end
      end else begin
        if ($urandom_range(0, 1)) now_ms = $urandom();
        else now_ms += step_ms();
        send_sample(SAMPLE_W'($urandom_range(0, 4095)), now_ms);
        sent++;
      end
    end
  endtask

  task automatic ladder_levels();
    lvl = '{400, 1200, 2000, 2800, 3600};
  endtask

  task automatic random_levels();
    int i;
    for (i = 0; i < MAX_BUTTONS; i++) lvl[i] = $urandom_range(0, 4095);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(12'd0, 32'd0);
    send_sample(12'hFFF, 32'hFFFF_FFFF);
    drain();

    ladder_levels();
    apply_config(5, 300, 100);
    send_sample(12'd400, 32'd1000);
    send_sample(12'd410, 32'd1010);
    send_sample(12'hFFF, 32'd1020);
    send_sample(12'd1200, 32'd2000);
    send_sample(12'd1250, 32'd2300);
    send_sample(12'd1150, 32'd2600);
    send_sample(12'd1100, 32'd2650);
    send_sample(12'd2099, 32'd2700);
    send_sample(12'd2800, 32'd2999);
    send_sample(12'd2800, 32'd3299);
    send_sample(12'd2900, 32'd3300);
    send_sample(12'd3600, 32'hFFFF_FF00);
    send_sample(12'd3600, 32'h0000_002C);
    send_sample(12'd0, 32'h0000_0030);
    drain();

    lvl = '{0, 4095, 2048, 1, 4094};
    apply_config(7, 0, 4095);
    send_sample(12'd100, 32'd5);
    send_sample(12'd200, 32'd5);
    send_sample(12'hFFF, 32'd6);
    send_sample(12'hFFF, 32'd6);
    drain();

    for (phase = 0; phase < 7; phase++) begin
      now_ms = $urandom();
      case (phase)
        0: begin
          ladder_levels();
          apply_config(5, 300, 100);
          gap_max = 3;
          stall_mode = 1;
        end
        1: begin
          random_levels();
          apply_config($urandom_range(0, 7), $urandom_range(1, 2000), $urandom_range(0, 400));
          gap_max = 8;
          stall_mode = 2;
        end
        2: begin
          ladder_levels();
          apply_config(5, 0, 150);
          gap_max = 0;
          stall_mode = 0;
        end
        3: begin
          random_levels();
          lvl[0] = 0;
          lvl[1] = 4095;
          apply_config(5, 65535, 4095);
          gap_max = 10;
          stall_mode = 1;
          now_ms = 32'hFFFF_0000;
        end
        4: begin
          random_levels();
          apply_config(5, 1, 0);
          gap_max = 2;
          stall_mode = 2;
        end
        5: begin
          random_levels();
          apply_config($urandom_range(0, 7), $urandom_range(0, 65535),
                       $urandom_range(0, 4095));
          gap_max = 4;
          stall_mode = 0;
        end
        default: begin
          ladder_levels();
          apply_config(4, 50, 60);
          gap_max = 1;
          stall_mode = 1;
        end
      endcase
      run_gestures(phase == 4 ? 60 : 180);
      drain();
    end

    $display("Sent %0d samples under %0d register settings; %0d results compared.",
             samples_sent, settings_count, compared);
    $display("Predicted short presses: %0d, hold events: %0d.", shorts, holds);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/rlbd_pkg.sv
sv/rlbd_regs.sv
sv/rlbd_front.sv
sv/rlbd_queue.sv
sv/rlbd_back.sv
sv/resistor_ladder_button_decoder.sv
dv/button_event_checker.sv
dv/testbench.sv
